### rtl/core/spk_pkg.sv
// Shared types and constants for the Speck 64/128 block decrypt unit.
package spk_pkg;

    // Field widths fixed by the block format.
    localparam int WORD_W = 32;
    localparam int KIDX_W = 5;

    // Rotation amounts of the inverse round.
    localparam int ROT_R = 3;
    localparam int ROT_L = 8;

    // Operation codes of an input item.
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // Input item.
    typedef struct packed {
        logic              operation;
        logic [KIDX_W-1:0] key_index;
        logic [WORD_W-1:0] key_word;
        logic [WORD_W-1:0] cipher_right;
        logic [WORD_W-1:0] cipher_left;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [WORD_W-1:0] plain_right;
        logic [WORD_W-1:0] plain_left;
    } out_item_t;

    // Sequencer states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

endpackage

### rtl/core/spk_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module spk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 27
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/core/speck64_128_block_decrypt_unit.sv
// Top level of the Speck 64/128 block decrypt unit with its round key store.
// A load keeps the block idle; the next item is accepted in the following cycle.
// A decrypt item runs one round per cycle with one key read per round from the
// key RAM, but its last round waits while a previous result is still held. The
// result shows on m_valid as the block goes idle; only then is a new item taken.
// Reset clears the sequencer and the result valid; the key store keeps its contents.
module speck64_128_block_decrypt_unit #(
    parameter int ROUNDS = 27
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  spk_pkg::in_item_t s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output spk_pkg::out_item_t m_item
);

    localparam int IDX_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int CMP_W = spk_pkg::KIDX_W + 1;

    spk_pkg::state_t           state_reg, state_next;
    logic [IDX_W-1:0]          round_reg, round_next;
    logic [spk_pkg::WORD_W-1:0] right_reg, right_next;
    logic [spk_pkg::WORD_W-1:0] left_reg, left_next;
    logic                      out_valid_reg, out_valid_next;
    spk_pkg::out_item_t        out_item_reg, out_item_next;

    logic                      accept;
    logic                      key_wr_en;
    logic [IDX_W-1:0]          key_rd_addr;
    logic [spk_pkg::WORD_W-1:0] key_rd_data;
    logic [spk_pkg::WORD_W-1:0] round_right;
    logic [spk_pkg::WORD_W-1:0] round_left;
    logic [spk_pkg::WORD_W-1:0] diff;
    logic                      last_round;
    logic                      advance;

    assign s_ready = (state_reg == spk_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;

    // A load with an index beyond the key store is dropped.
    assign key_wr_en = accept && (s_item.operation == spk_pkg::OP_LOAD) &&
                       ({1'b0, s_item.key_index} < CMP_W'(ROUNDS));

    // Inverse round on the working words.
    assign round_right = {right_reg ^ left_reg} >> spk_pkg::ROT_R |
                         {right_reg ^ left_reg} << (spk_pkg::WORD_W - spk_pkg::ROT_R);
    assign diff        = (left_reg ^ key_rd_data) - round_right;
    assign round_left  = (diff << spk_pkg::ROT_L) | (diff >> (spk_pkg::WORD_W - spk_pkg::ROT_L));

    // The last round waits while the previous result is still held.
    assign last_round = (round_reg == '0);
    assign advance    = !(last_round && out_valid_reg && !m_ready);

    // Key read address: the top key is fetched while idle so it is ready for
    // the first round; the read address holds during a stall. The store is not
    // written while a decrypt runs, so no write meets a round key read.
    always_comb begin
        if (state_reg == spk_pkg::ST_IDLE) begin
            key_rd_addr = IDX_W'(ROUNDS - 1);
        end else if (advance && !last_round) begin
            key_rd_addr = round_reg - 1'b1;
        end else begin
            key_rd_addr = round_reg;
        end
    end

    spk_ram #(
        .WIDTH(spk_pkg::WORD_W),
        .DEPTH(ROUNDS)
    ) u_key_ram (
        .aclk   (aclk),
        .wr_en  (key_wr_en),
        .wr_addr(s_item.key_index[IDX_W-1:0]),
        .wr_data(s_item.key_word),
        .rd_addr(key_rd_addr),
        .rd_data(key_rd_data)
    );

    // Sequencer and output register.
    always_comb begin
        state_next     = state_reg;
        round_next     = round_reg;
        right_next     = right_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            spk_pkg::ST_IDLE: begin
                if (accept && (s_item.operation == spk_pkg::OP_DECRYPT)) begin
                    right_next = s_item.cipher_right;
                    left_next  = s_item.cipher_left;
                    round_next = IDX_W'(ROUNDS - 1);
                    state_next = spk_pkg::ST_RUN;
                end
            end
            spk_pkg::ST_RUN: begin
                if (advance) begin
                    right_next = round_right;
                    left_next  = round_left;
                    if (last_round) begin
                        out_item_next.plain_right = round_right;
                        out_item_next.plain_left  = round_left;
                        out_valid_next            = 1'b1;
                        state_next                = spk_pkg::ST_IDLE;
                    end else begin
                        round_next = round_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = spk_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= spk_pkg::ST_IDLE;
            round_reg     <= '0;
            right_reg     <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            right_reg     <= right_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_item_reg <= out_item_next;
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

### rtl/core/spk_checker.sv
// Port-level checker for the Speck 64/128 block decrypt unit, bound to the top level.
module spk_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input spk_pkg::in_item_t  s_item,
    input logic               m_valid,
    input logic               m_ready,
    input spk_pkg::out_item_t m_item
);

    // A held result stays put until it is taken.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_item)))
        else $error("result changed or dropped while stalled");

    // A decrypt item makes the block busy in the next cycle.
    a_decrypt_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_item.operation == spk_pkg::OP_DECRYPT)) |=> !s_ready)
        else $error("input still ready right after a decrypt item");

    // No result can appear in the cycle after a decrypt item is accepted while none is pending.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid && s_valid && s_ready && (s_item.operation == spk_pkg::OP_DECRYPT))
        |=> !m_valid)
        else $error("result appeared too early");

    // Reset leaves no result pending and the input open.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("block not idle after reset");

endmodule

bind speck64_128_block_decrypt_unit spk_checker u_spk_checker (.*);

### verif/speck64_128_block_decrypt_unit_tb.sv
// Self-checking testbench for the Speck 64/128 block decrypt unit and its round key store.
`timescale 1ns / 100ps

module speck64_128_block_decrypt_unit_tb;

    localparam int NUM_ROUNDS     = 27;
    localparam int ITEMS_PER_PASS = 550;
    localparam int DRAIN_CYCLES   = 2 * (NUM_ROUNDS + 1);
    localparam int STALL_CYCLES   = 400;
    localparam int STALL_AFTER    = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_PRINTS     = 50;

    // Ways of filling the whole key store in one burst of load items.
    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } key_fill_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    spk_pkg::in_item_t  s_item  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    spk_pkg::out_item_t m_item;

    // Items waiting for the driver and plaintexts waiting for the block.
    spk_pkg::in_item_t  pending_items[$];
    spk_pkg::out_item_t plain_q[$];

    // Predictor copy of the round key store.
    logic [spk_pkg::WORD_W-1:0] key_mem[NUM_ROUNDS];

    int send_idle_pct = 17;
    int recv_idle_pct = 79;
    int err_cnt       = 0;
    int results_seen  = 0;
    int quiet_cycles  = 0;
    int stall_left    = 0;
    bit stall_done    = 1'b0;

    speck64_128_block_decrypt_unit #(
        .ROUNDS(NUM_ROUNDS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #4 aclk = ~aclk;

    // Prints one mismatch line, up to a cap, and counts every one.
    task automatic report_mismatch(input string msg);
        if (err_cnt < MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        err_cnt++;
    endtask

    // A random word with extra weight on the two extremes.
    function automatic logic [spk_pkg::WORD_W-1:0] rand_word();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return '1;
        end
        return $urandom();
    endfunction

    // Runs all inverse rounds, last round key first.
    function automatic spk_pkg::out_item_t decrypt_block(
        input logic [spk_pkg::WORD_W-1:0] y,
        input logic [spk_pkg::WORD_W-1:0] x);
        logic [spk_pkg::WORD_W-1:0] r;
        logic [spk_pkg::WORD_W-1:0] l;
        logic [spk_pkg::WORD_W-1:0] t;
        spk_pkg::out_item_t         res;
        r = y;
        l = x;
        for (int i = NUM_ROUNDS - 1; i >= 0; i--) begin
            r = r ^ l;
            r = (r >> spk_pkg::ROT_R) | (r << (spk_pkg::WORD_W - spk_pkg::ROT_R));
            t = (l ^ key_mem[i]) - r;
            l = (t << spk_pkg::ROT_L) | (t >> (spk_pkg::WORD_W - spk_pkg::ROT_L));
        end
        res.plain_right = r;
        res.plain_left  = l;
        return res;
    endfunction

    // Queues a load item; the cipher fields carry noise the block must ignore.
    task automatic push_load(input int idx, input logic [spk_pkg::WORD_W-1:0] word);
        spk_pkg::in_item_t it;
        it.operation    = spk_pkg::OP_LOAD;
        it.key_index    = idx[spk_pkg::KIDX_W-1:0];
        it.key_word     = word;
        it.cipher_right = $urandom();
        it.cipher_left  = $urandom();
        pending_items.push_back(it);
    endtask

    // Queues a decrypt item; the key fields carry noise the block must ignore.
    task automatic push_decrypt(input logic [spk_pkg::WORD_W-1:0] y,
                                input logic [spk_pkg::WORD_W-1:0] x);
        spk_pkg::in_item_t it;
        logic [31:0]       noise;
        noise           = $urandom();
        it.operation    = spk_pkg::OP_DECRYPT;
        it.key_index    = noise[spk_pkg::KIDX_W-1:0];
        it.key_word     = $urandom();
        it.cipher_right = y;
        it.cipher_left  = x;
        pending_items.push_back(it);
    endtask

    // Reloads the whole key store in index order.
    task automatic push_key_fill(input key_fill_t fill);
        logic [spk_pkg::WORD_W-1:0] word;
        for (int i = 0; i < NUM_ROUNDS; i++) begin
            case (fill)
                FILL_ZERO: word = '0;
                FILL_ONES: word = '1;
                default:   word = rand_word();
            endcase
            push_load(i, word);
        end
    endtask

    // Fills one pass of random traffic; ignored loads are not counted.
    task automatic push_random_pass();
        int counted;
        int pick;
        counted = 0;
        while (counted < ITEMS_PER_PASS) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                push_key_fill(key_fill_t'($urandom_range(0, 2)));
                counted += NUM_ROUNDS;
            end else if (pick < 16) begin
                push_load($urandom_range(0, NUM_ROUNDS - 1), rand_word());
                counted++;
            end else if (pick < 19) begin
                push_load($urandom_range(NUM_ROUNDS, 31), $urandom());
            end else begin
                push_decrypt(rand_word(), rand_word());
                counted++;
            end
        end
    endtask

    // Blocks until every queued item went in and every plaintext came out.
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || plain_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Driver: offers the next pending item, idling at random between items.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_item  <= pending_items.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure plus one long hold-off to fill the block.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!stall_done && results_seen >= STALL_AFTER) begin
            m_ready    <= 1'b0;
            stall_left <= STALL_CYCLES;
            stall_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: predicts on each accepted input item, checks each result, runs the watchdog.
    always @(posedge aclk) begin
        spk_pkg::out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (s_item.operation == spk_pkg::OP_LOAD) begin
                    if (s_item.key_index < NUM_ROUNDS) begin
                        key_mem[s_item.key_index] = s_item.key_word;
                    end
                end else begin
                    plain_q.push_back(decrypt_block(s_item.cipher_right, s_item.cipher_left));
                end
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (plain_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h_%h",
                                              m_item.plain_right, m_item.plain_left));
                end else begin
                    want = plain_q.pop_front();
                    if (m_item.plain_right !== want.plain_right) begin
                        report_mismatch($sformatf("plain_right got %h want %h",
                                                  m_item.plain_right, want.plain_right));
                    end
                    if (m_item.plain_left !== want.plain_left) begin
                        report_mismatch($sformatf("plain_left got %h want %h",
                                                  m_item.plain_left, want.plain_left));
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL speck64_128_block_decrypt_unit");
                $finish;
            end
        end
    end

    // Stimulus and the end of the run.
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Every key gets written before the first decrypt, with both extremes present.
        for (int i = 0; i < NUM_ROUNDS; i++) begin
            push_load(i, (i == 0) ? '0 : (i == NUM_ROUNDS - 1) ? '1 : $urandom());
        end
        // Loads beyond the store must change nothing.
        push_load(NUM_ROUNDS, '1);
        push_load(31, 32'hA5A5_5A5A);
        push_decrypt('0, '0);
        push_decrypt('1, '1);
        push_decrypt('1, '0);
        push_decrypt('0, '1);
        push_decrypt(32'hAAAA_AAAA, 32'h5555_5555);
        push_decrypt(32'h8000_0000, 32'h0000_0001);
        push_decrypt(32'h7FFF_FFFF, 32'hFFFF_FFFE);
        push_decrypt($urandom(), $urandom());

        push_random_pass();
        wait_drained();

        send_idle_pct = 79;
        recv_idle_pct = 17;
        push_random_pass();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random_pass();
        wait_drained();

        if (plain_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", plain_q.size()));
        end
        if (err_cnt == 0) begin
            $display("PASS speck64_128_block_decrypt_unit");
        end else begin
            $display("FAIL speck64_128_block_decrypt_unit");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/spk_pkg.sv
rtl/core/spk_ram.sv
rtl/core/speck64_128_block_decrypt_unit.sv
rtl/core/spk_checker.sv
verif/speck64_128_block_decrypt_unit_tb.sv
